// ----- rtl/tlpq_pkg.sv -----
package tlpq_pkg;

    localparam int TAG_FIELD_W = 16;
    localparam int OCC_W       = 7;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_POP    = 1'b1;

    localparam logic [1:0] CLS_NONE   = 2'd0;
    localparam logic [1:0] CLS_LOW    = 2'd1;
    localparam logic [1:0] CLS_MEDIUM = 2'd2;
    localparam logic [1:0] CLS_HIGH   = 2'd3;

    // Segment index is the class minus one.
    localparam int         NUM_SEGS   = 3;
    localparam logic [1:0] SEG_LOW    = 2'd0;
    localparam logic [1:0] SEG_MEDIUM = 2'd1;
    localparam logic [1:0] SEG_HIGH   = 2'd2;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic                   is_pop;
        logic [TAG_FIELD_W-1:0] tag;
        logic [1:0]             cls;
    } t_req;

    typedef struct packed {
        logic [1:0]             status;
        logic [TAG_FIELD_W-1:0] tag;
        logic [1:0]             cls;
        logic [OCC_W-1:0]       occupancy;
    } t_rsp;

endpackage

// ----- rtl/tlpq_front.sv -----
module tlpq_front
    import tlpq_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_action,
    input  logic [TAG_FIELD_W-1:0] i_item_tag,
    input  logic [1:0]             i_item_class,
    output logic                   o_req_valid,
    output t_req                   o_req,
    input  logic                   i_req_take
);

    t_req              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              push;
    logic              pop;
    t_req              req_in;

    // A request with class zero is given the low class.
    always_comb begin
        req_in.is_pop = (i_action == ACT_POP);
        req_in.tag    = i_item_tag;
        req_in.cls    = (i_item_class == CLS_NONE) ? CLS_LOW : i_item_class;
    end

    assign o_in_stall  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign push        = i_in_valid && !o_in_stall;
    assign pop         = i_req_take && (r_cnt != '0);
    assign o_req_valid = (r_cnt != '0);
    assign o_req       = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_cnt    = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= req_in;
        end
    end

endmodule

// ----- rtl/tlpq_back.sv -----
module tlpq_back
    import tlpq_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int TAG_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  t_req i_req,
    output logic o_req_take,
    input  logic i_rsp_ready,
    output logic o_rsp_valid,
    output t_rsp o_rsp
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    t_state              r_state, n_state;
    logic [NUM_SEGS-1:0] r_seg_valid, n_seg_valid;
    logic [IDX_W-1:0]    r_head [NUM_SEGS];
    logic [IDX_W-1:0]    n_head [NUM_SEGS];
    logic [IDX_W-1:0]    r_tail [NUM_SEGS];
    logic [IDX_W-1:0]    n_tail [NUM_SEGS];
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_fresh, n_fresh;
    logic [IDX_W-1:0]    r_free_head, n_free_head;

    // Request being carried out.
    logic                r_is_pop, n_is_pop;
    logic [1:0]          r_seg, n_seg;
    logic [TAG_BITS-1:0] r_tag, n_tag;
    logic [IDX_W-1:0]    r_slot, n_slot;
    logic                r_use_free, n_use_free;

    logic [IDX_W-1:0]    r_link_mem [CAPACITY];
    logic [IDX_W-1:0]    r_link_rdata;
    logic [TAG_BITS-1:0] r_entry_mem [CAPACITY];
    logic [TAG_BITS-1:0] r_entry_rdata;

    logic                link_we, link_re;
    logic [IDX_W-1:0]    link_waddr, link_wdata, link_raddr;
    logic                entry_we, entry_re;
    logic [IDX_W-1:0]    entry_waddr, entry_raddr;
    logic [1:0]          top_seg;

    always_comb begin
        if (r_seg_valid[SEG_HIGH]) begin
            top_seg = SEG_HIGH;
        end else if (r_seg_valid[SEG_MEDIUM]) begin
            top_seg = SEG_MEDIUM;
        end else begin
            top_seg = SEG_LOW;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_seg_valid = r_seg_valid;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_fresh     = r_fresh;
        n_free_head = r_free_head;
        n_is_pop    = r_is_pop;
        n_seg       = r_seg;
        n_tag       = r_tag;
        n_slot      = r_slot;
        n_use_free  = r_use_free;
        link_we     = 1'b0;
        link_waddr  = r_slot;
        link_wdata  = r_free_head;
        link_re     = 1'b0;
        link_raddr  = r_free_head;
        entry_we    = 1'b0;
        entry_waddr = r_slot;
        entry_re    = 1'b0;
        entry_raddr = r_head[top_seg];
        o_req_take  = 1'b0;
        o_rsp_valid = 1'b0;
        o_rsp       = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    if (!i_req.is_pop && (r_count >= CAP_CNT)) begin
                        if (i_rsp_ready) begin
                            o_req_take       = 1'b1;
                            o_rsp_valid      = 1'b1;
                            o_rsp.status     = STATUS_FULL;
                            o_rsp.occupancy  = OCC_W'(r_count);
                        end
                    end else if (i_req.is_pop && (r_count == '0)) begin
                        if (i_rsp_ready) begin
                            o_req_take       = 1'b1;
                            o_rsp_valid      = 1'b1;
                            o_rsp.status     = STATUS_EMPTY;
                            o_rsp.occupancy  = OCC_W'(r_count);
                        end
                    end else if (!i_req.is_pop) begin
                        // Reuse a freed slot first; its link gives the next free slot.
                        o_req_take = 1'b1;
                        n_is_pop   = 1'b0;
                        n_seg      = i_req.cls - 2'd1;
                        n_tag      = TAG_BITS'(i_req.tag);
                        n_use_free = (r_count < r_fresh);
                        n_slot     = n_use_free ? r_free_head : IDX_W'(r_fresh);
                        link_re    = 1'b1;
                        link_raddr = r_free_head;
                        n_state    = ST_EXEC;
                    end else begin
                        o_req_take  = 1'b1;
                        n_is_pop    = 1'b1;
                        n_seg       = top_seg;
                        n_slot      = r_head[top_seg];
                        link_re     = 1'b1;
                        link_raddr  = r_head[top_seg];
                        entry_re    = 1'b1;
                        entry_raddr = r_head[top_seg];
                        n_state     = ST_EXEC;
                    end
                end
            end
            ST_EXEC: begin
                if (i_rsp_ready) begin
                    o_rsp_valid  = 1'b1;
                    o_rsp.status = STATUS_DONE;
                    n_state      = ST_IDLE;
                    if (!r_is_pop) begin
                        entry_we    = 1'b1;
                        entry_waddr = r_slot;
                        if (r_seg_valid[r_seg]) begin
                            link_we    = 1'b1;
                            link_waddr = r_tail[r_seg];
                            link_wdata = r_slot;
                        end else begin
                            n_head[r_seg] = r_slot;
                        end
                        n_tail[r_seg]      = r_slot;
                        n_seg_valid[r_seg] = 1'b1;
                        if (r_use_free) begin
                            n_free_head = r_link_rdata;
                        end else begin
                            n_fresh = r_fresh + 1'b1;
                        end
                        n_count = r_count + 1'b1;
                    end else begin
                        o_rsp.tag = TAG_FIELD_W'(r_entry_rdata);
                        o_rsp.cls = r_seg + 2'd1;
                        if (r_head[r_seg] == r_tail[r_seg]) begin
                            n_seg_valid[r_seg] = 1'b0;
                        end else begin
                            n_head[r_seg] = r_link_rdata;
                        end
                        // The popped slot goes onto the front of the free list.
                        link_we     = 1'b1;
                        link_waddr  = r_slot;
                        link_wdata  = r_free_head;
                        n_free_head = r_slot;
                        n_count     = r_count - 1'b1;
                    end
                    o_rsp.occupancy = OCC_W'(n_count);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_seg_valid <= '0;
            r_count     <= '0;
            r_fresh     <= '0;
            r_free_head <= '0;
        end else begin
            r_state     <= n_state;
            r_seg_valid <= n_seg_valid;
            r_count     <= n_count;
            r_fresh     <= n_fresh;
            r_free_head <= n_free_head;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head     <= n_head;
        r_tail     <= n_tail;
        r_is_pop   <= n_is_pop;
        r_seg      <= n_seg;
        r_tag      <= n_tag;
        r_slot     <= n_slot;
        r_use_free <= n_use_free;
    end

    always_ff @(posedge i_clk) begin
        if (link_we) begin
            r_link_mem[link_waddr] <= link_wdata;
        end
        if (link_re) begin
            r_link_rdata <= r_link_mem[link_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (entry_we) begin
            r_entry_mem[entry_waddr] <= r_tag;
        end
        if (entry_re) begin
            r_entry_rdata <= r_entry_mem[entry_raddr];
        end
    end

`ifndef NO_ASSERTIONS
    a_segs_match_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seg_valid != '0) == (r_count != '0))
        else $error("segment valid bits disagree with item count");

    a_fresh_covers_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh >= r_count && r_count <= CAP_CNT)
        else $error("item count exceeds slots handed out");

    a_pop_decrements: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC && i_rsp_ready && r_is_pop)
        |=> (r_count == $past(r_count) - 1'b1))
        else $error("completed pop did not lower the item count");
`endif

endmodule

// ----- rtl/tlpq_out.sv -----
module tlpq_out
    import tlpq_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_rsp_valid,
    input  t_rsp                   i_rsp,
    output logic                   o_rsp_ready,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [1:0]             o_status,
    output logic [TAG_FIELD_W-1:0] o_popped_tag,
    output logic [1:0]             o_popped_class,
    output logic [OCC_W-1:0]       o_occupancy
);

    logic r_valid, n_valid;
    t_rsp r_rsp;

    // A new result may enter in the same cycle that the held one is taken.
    assign o_rsp_ready = !r_valid || !i_out_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_rsp_valid && o_rsp_ready) begin
            n_valid = 1'b1;
        end else if (r_valid && !i_out_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rsp_valid && o_rsp_ready) begin
            r_rsp <= i_rsp;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_status       = r_rsp.status;
    assign o_popped_tag   = r_rsp.tag;
    assign o_popped_class = r_rsp.cls;
    assign o_occupancy    = r_rsp.occupancy;

endmodule

// ----- rtl/three_level_priority_queue_core.sv -----
// Strict three-class priority queue over a shared slot store.
// Input channel: i_in_valid / o_in_stall with i_action (0 insert, 1 pop),
// i_item_tag and i_item_class (1 low, 2 medium, 3 high; 0 is taken as low).
// Output channel: o_out_valid / i_out_stall with one result per request:
// o_status (0 done, 1 insert refused when full, 2 pop refused when empty),
// o_popped_tag and o_popped_class of the popped item (zero otherwise) and
// o_occupancy, the number of items held after the request.
// Requests enter a two-entry queue; the executer takes one at a time.
// A served request reads the link memory (a pop also the entry memory) in
// the idle state and writes the memories in the execute state once the output
// can take its result; the executer takes no new request until then. A refused
// request is answered straight from the idle state. Every result passes
// through the output register before it appears.
// Reset empties the queue and all three classes; no clearing pass is run.
// When the receiver stalls, the result is held in the output register, one
// more finished result waits in the executer, and o_in_stall rises once the
// two-entry request queue is full.
module three_level_priority_queue_core
    import tlpq_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int TAG_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_action,
    input  logic [TAG_FIELD_W-1:0] i_item_tag,
    input  logic [1:0]             i_item_class,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [1:0]             o_status,
    output logic [TAG_FIELD_W-1:0] o_popped_tag,
    output logic [1:0]             o_popped_class,
    output logic [OCC_W-1:0]       o_occupancy
);

    logic req_valid;
    t_req req;
    logic req_take;
    logic rsp_ready;
    logic rsp_valid;
    t_rsp rsp;

    tlpq_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_action     (i_action),
        .i_item_tag   (i_item_tag),
        .i_item_class (i_item_class),
        .o_req_valid  (req_valid),
        .o_req        (req),
        .i_req_take   (req_take)
    );

    tlpq_back #(
        .CAPACITY (CAPACITY),
        .TAG_BITS (TAG_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .i_req       (req),
        .o_req_take  (req_take),
        .i_rsp_ready (rsp_ready),
        .o_rsp_valid (rsp_valid),
        .o_rsp       (rsp)
    );

    tlpq_out u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rsp_valid    (rsp_valid),
        .i_rsp          (rsp),
        .o_rsp_ready    (rsp_ready),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_popped_tag   (o_popped_tag),
        .o_popped_class (o_popped_class),
        .o_occupancy    (o_occupancy)
    );

endmodule

// ----- tb/three_level_priority_queue_core_tb.sv -----
`timescale 1ns / 1ps

module three_level_priority_queue_core_tb;
    import tlpq_pkg::*;

    localparam int STORE_SLOTS    = 64;
    localparam int CLK_HALF_NS    = 10;
    localparam int RESET_CYCLES   = 9;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 940;

    // Receiver behavior on the result channel.
    localparam int STALL_NONE  = 0;
    localparam int STALL_MIXED = 1;
    localparam int STALL_HEAVY = 2;

    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   i_in_valid     = 1'b0;
    logic                   i_action       = ACT_INSERT;
    logic [TAG_FIELD_W-1:0] i_item_tag     = '0;
    logic [1:0]             i_item_class   = CLS_LOW;
    logic                   i_out_stall    = 1'b0;
    logic                   o_in_stall;
    logic                   o_out_valid;
    logic [1:0]             o_status;
    logic [TAG_FIELD_W-1:0] o_popped_tag;
    logic [1:0]             o_popped_class;
    logic [OCC_W-1:0]       o_occupancy;

    three_level_priority_queue_core #(
        .CAPACITY(STORE_SLOTS),
        .TAG_BITS(TAG_FIELD_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_item_tag    (i_item_tag),
        .i_item_class  (i_item_class),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_popped_tag  (o_popped_tag),
        .o_popped_class(o_popped_class),
        .o_occupancy   (o_occupancy)
    );

    // Independent picture of the queue: one FIFO of tags per class.
    logic [TAG_FIELD_W-1:0] high_items[$];
    logic [TAG_FIELD_W-1:0] medium_items[$];
    logic [TAG_FIELD_W-1:0] low_items[$];
    t_rsp                   expected_replies[$];

    int  error_count     = 0;
    int  insert_count    = 0;
    int  pop_count       = 0;
    int  full_refusals   = 0;
    int  empty_refusals  = 0;
    int  peak_occupancy  = 0;
    bit  sender_idles    = 1'b0;
    int  stall_mode      = STALL_NONE;
    int  stall_left      = 0;

    initial begin
        forever #(CLK_HALF_NS) i_clk = ~i_clk;
    end

    function automatic int held_items();
        return high_items.size() + medium_items.size() + low_items.size();
    endfunction

    function automatic t_rsp predict_reply(input logic act, input logic [TAG_FIELD_W-1:0] tag,
                                           input logic [1:0] cls);
        t_rsp reply;
        reply = '0;
        if (act == ACT_INSERT) begin
            if (held_items() >= STORE_SLOTS) begin
                reply.status = STATUS_FULL;
            end else begin
                case (cls)
                    CLS_HIGH:   high_items.push_back(tag);
                    CLS_MEDIUM: medium_items.push_back(tag);
                    default:    low_items.push_back(tag);
                endcase
            end
        end else begin
            if (high_items.size() != 0) begin
                reply.tag = high_items.pop_front();
                reply.cls = CLS_HIGH;
            end else if (medium_items.size() != 0) begin
                reply.tag = medium_items.pop_front();
                reply.cls = CLS_MEDIUM;
            end else if (low_items.size() != 0) begin
                reply.tag = low_items.pop_front();
                reply.cls = CLS_LOW;
            end else begin
                reply.status = STATUS_EMPTY;
            end
        end
        reply.occupancy = OCC_W'(held_items());
        return reply;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (!sender_idles || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [1:0] pick_class();
        if ($urandom_range(0, 9) == 0)
            return CLS_NONE;
        return 2'($urandom_range(CLS_LOW, CLS_HIGH));
    endfunction

    function automatic logic [TAG_FIELD_W-1:0] pick_tag();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return TAG_FIELD_W'($urandom());
        endcase
    endfunction

    // Called right after a rising edge; returns right after the edge that took the request.
    task automatic send_request(input logic act, input logic [TAG_FIELD_W-1:0] tag,
                                input logic [1:0] cls);
        int   gap;
        t_rsp reply;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_item_tag   <= tag;
        i_item_class <= cls;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        reply = predict_reply(act, tag, cls);
        expected_replies.push_back(reply);
        if (act == ACT_INSERT)
            insert_count++;
        else
            pop_count++;
        if (reply.status == STATUS_FULL)
            full_refusals++;
        if (reply.status == STATUS_EMPTY)
            empty_refusals++;
        if (held_items() > peak_occupancy)
            peak_occupancy = held_items();
    endtask

    task automatic send_insert(input logic [TAG_FIELD_W-1:0] tag, input logic [1:0] cls);
        send_request(ACT_INSERT, tag, cls);
    endtask

    // Tag and class mean nothing on a pop, so they carry noise.
    task automatic send_pop();
        send_request(ACT_POP, pick_tag(), 2'($urandom_range(0, 3)));
    endtask

    task automatic wait_for_replies();
        while (expected_replies.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        sender_idles = 1'b1;
        stall_mode   = STALL_MIXED;
        send_pop();
        send_insert(16'h0000, CLS_LOW);
        send_insert(16'hFFFF, CLS_MEDIUM);
        send_insert(16'hA5A5, CLS_HIGH);
        send_insert(16'h5A5A, CLS_NONE);
        send_insert(16'h0001, CLS_HIGH);
        send_insert(16'h8000, CLS_MEDIUM);
        repeat (7) send_pop();
        // A high request must go in front of a waiting low one, medium between them.
        send_insert(16'h1111, CLS_LOW);
        send_insert(16'h3333, CLS_HIGH);
        send_insert(16'h2222, CLS_MEDIUM);
        send_insert(16'h4444, CLS_LOW);
        repeat (4) send_pop();
    endtask

    task automatic test_full_and_empty();
        sender_idles = 1'b1;
        stall_mode   = STALL_MIXED;
        repeat (STORE_SLOTS) send_insert(pick_tag(), pick_class());
        // Let the store settle completely before asking for more room.
        i_in_valid <= 1'b0;
        wait_for_replies();
        send_insert(pick_tag(), CLS_HIGH);
        send_insert(pick_tag(), pick_class());
        repeat (STORE_SLOTS + 2) send_pop();
    endtask

    task automatic test_back_to_back();
        int k;
        sender_idles = 1'b0;
        stall_mode   = STALL_NONE;
        for (k = 0; k < 30; k++) begin
            if (k % 3 == 2)
                send_pop();
            else
                send_insert(pick_tag(), pick_class());
        end
        // Heavy backpressure with no sender gaps fills the request queue.
        stall_mode = STALL_HEAVY;
        for (k = 0; k < 30; k++) begin
            if (k % 2 == 1)
                send_pop();
            else
                send_insert(pick_tag(), pick_class());
        end
    endtask

    task automatic test_random_traffic(input int n_items);
        int sent;
        int phase_len;
        int insert_pct;
        int k;
        sent = 0;
        while (sent < n_items) begin
            phase_len = $urandom_range(40, 120);
            case ($urandom_range(0, 4))
                0:       insert_pct = 85;
                1:       insert_pct = 15;
                default: insert_pct = $urandom_range(35, 65);
            endcase
            sender_idles = ($urandom_range(0, 3) != 0);
            stall_mode   = $urandom_range(STALL_NONE, STALL_HEAVY);
            for (k = 0; k < phase_len && sent < n_items; k++) begin
                if ($urandom_range(0, 99) < insert_pct)
                    send_insert(pick_tag(), pick_class());
                else
                    send_pop();
                sent++;
            end
        end
    endtask

    // Result checking and receiver stall, both on values from before the edge.
    always @(posedge i_clk) begin
        t_rsp want;
        if (o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (expected_replies.size() == 0) begin
                $error("unexpected result: status %0d tag %h class %0d occupancy %0d",
                       o_status, o_popped_tag, o_popped_class, o_occupancy);
                error_count++;
            end else begin
                want = expected_replies.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    error_count++;
                end
                if (o_popped_tag !== want.tag) begin
                    $error("popped_tag: expected %h, got %h", want.tag, o_popped_tag);
                    error_count++;
                end
                if (o_popped_class !== want.cls) begin
                    $error("popped_class: expected %0d, got %0d", want.cls, o_popped_class);
                    error_count++;
                end
                if (o_occupancy !== want.occupancy) begin
                    $error("occupancy: expected %0d, got %0d", want.occupancy, o_occupancy);
                    error_count++;
                end
            end
        end

        if (stall_left > 0) begin
            stall_left--;
        end else if (stall_mode == STALL_NONE) begin
            i_out_stall <= 1'b0;
        end else begin
            if (stall_mode == STALL_HEAVY && $urandom_range(0, 1) == 0) begin
                i_out_stall <= 1'b1;
                stall_left  = $urandom_range(5, 20);
            end else if (stall_mode == STALL_MIXED && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                stall_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                          : $urandom_range(0, 2);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (i_rst_n !== 1'b1 || (i_in_valid && o_in_stall === 1'b0) ||
                (o_out_valid === 1'b1 && i_out_stall === 1'b0))
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_full_and_empty();
        test_back_to_back();
        test_random_traffic(RANDOM_ITEMS);

        i_in_valid <= 1'b0;
        stall_mode = STALL_NONE;
        wait_for_replies();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d inserts and %0d pops over all three classes, peak occupancy %0d.",
                 insert_count, pop_count, peak_occupancy);
        $display("Refused: %0d inserts on a full store, %0d pops on an empty one.",
                 full_refusals, empty_refusals);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/tlpq_pkg.sv
rtl/tlpq_front.sv
rtl/tlpq_back.sv
rtl/tlpq_out.sv
rtl/three_level_priority_queue_core.sv
tb/three_level_priority_queue_core_tb.sv
